/* rtl/core/ternary_max_heap_queue_core_assert.svh */
// ----------------------------------------------------------------------------
// ternary max-heap queue assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef TERNARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH
`define TERNARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define TMHQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tmhq assertion failed");
// checked at every edge, reset included
`define TMHQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tmhq assertion failed");
`else
`define TMHQ_ASSERT(lbl, clk, rst, prop)
`define TMHQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/tmhq_pkg.sv */
// ----------------------------------------------------------------------------
// tmhq_pkg
// shared types and constants of the ternary max-heap queue
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int KEY_W          = 32;
  localparam int CAP_W          = 11;
  localparam int CNT_OUT_W      = 11;
  localparam int HEAP_DEPTH_DEF = 1024;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t NEG_ONE = '1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic cmd;
    key_t key_in;
  } item_t;

  typedef struct packed {
    key_t                 removed_key;
    logic [1:0]           status;
    key_t                 top_key;
    logic                 heap_empty;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

endpackage

/* rtl/core/tmhq_mem.sv */
// ----------------------------------------------------------------------------
// tmhq_mem
// heap key store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tmhq_mem #(
  parameter int DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [tmhq_pkg::KEY_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [tmhq_pkg::KEY_W-1:0]   rdata
);
  import tmhq_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// tmhq_ctrl
// sift sequencer: walks the heap store one level at a time, holding the
// moving key in a register and writing each displaced entry back once
// ----------------------------------------------------------------------------
`include "ternary_max_heap_queue_core_assert.svh"

module tmhq_ctrl #(
  parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  tmhq_pkg::item_t                     req,
  input  logic                                full,
  output logic                                busy,
  output logic                                done,
  output tmhq_pkg::result_t                   rsp,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]     count
);
  import tmhq_pkg::*;

  localparam int AW      = $clog2(HEAP_DEPTH);
  localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int IW      = AW + 2;
  localparam int RECIP_S = AW + 1;
  localparam int PROD_W  = 2 * AW + 1;
  localparam logic [AW:0] RECIP_M = (AW + 1)'((1 << RECIP_S) / 3 + 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_UP_ADDR = 11'b000_0000_0010,
    S_UP_READ = 11'b000_0000_0100,
    S_UP_CMP  = 11'b000_0000_1000,
    S_DN_KEY  = 11'b000_0001_0000,
    S_DN_ADDR = 11'b000_0010_0000,
    S_DN_RD0  = 11'b000_0100_0000,
    S_DN_RD1  = 11'b000_1000_0000,
    S_DN_RD2  = 11'b001_0000_0000,
    S_DN_WAIT = 11'b010_0000_0000,
    S_DN_CMP  = 11'b100_0000_0000
  } state_t;

  state_t          state, state_next;
  logic [CNT_W-1:0] count_next;

  key_t            hkey;
  key_t            top;
  key_t            best_key;
  key_t            removed;
  logic [1:0]      status;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   parent;
  logic [AW-1:0]   best_idx;
  logic [IW-1:0]   c0;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  key_t            mem_wdata;
  logic [AW-1:0]   mem_raddr;
  key_t            mem_rdata;

  logic            accept;
  logic            finish;
  logic [IW-1:0]   cnt_ext;
  logic [IW-1:0]   first;
  logic [IW-1:0]   c1;
  logic [IW-1:0]   c2;
  logic            c1_ok;
  logic            c2_ok;
  logic            up_move;
  logic            dn_move;
  logic [PROD_W-1:0] parent_prod;
  logic [AW-1:0]   parent_calc;
  logic            rm_taken;
  logic            ins_dropped;

  tmhq_mem #(
    .DEPTH (HEAP_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cnt_ext = IW'(count);

  assign rm_taken    = accept && (req.cmd == CMD_REMOVE) && (count != '0);
  assign ins_dropped = accept && (req.cmd == CMD_INSERT) && full;

  // children start at 3*pos+1, parent is (pos-1)/3 by reciprocal multiply
  assign first       = (IW'(pos) << 1) + IW'(pos) + IW'(1);
  assign c1          = c0 + IW'(1);
  assign c2          = c0 + IW'(2);
  assign c1_ok       = c1 < cnt_ext;
  assign c2_ok       = c2 < cnt_ext;
  assign parent_prod = PROD_W'(pos - AW'(1)) * PROD_W'(RECIP_M);
  assign parent_calc = AW'(parent_prod >> RECIP_S);
  assign up_move     = hkey > mem_rdata;
  assign dn_move     = hkey < best_key;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = hkey;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        // fetch the last entry in case this is a remove
        mem_raddr = AW'(count - CNT_W'(1));
      end
      S_UP_ADDR: begin
        mem_we = (pos == '0);
      end
      S_UP_READ: begin
        mem_raddr = parent;
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_move) begin
          mem_wdata = mem_rdata;
        end
      end
      S_DN_ADDR: begin
        mem_we = (first >= cnt_ext);
      end
      S_DN_RD0: begin
        mem_raddr = AW'(c0);
      end
      S_DN_RD1: begin
        mem_raddr = AW'(c1);
      end
      S_DN_RD2: begin
        mem_raddr = AW'(c2);
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_move) begin
          mem_wdata = best_key;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_INSERT) begin
            if (!full) begin
              count_next = count + CNT_W'(1);
              state_next = S_UP_ADDR;
            end
          end else if (count != '0) begin
            count_next = count - CNT_W'(1);
            if (count != CNT_W'(1)) begin
              state_next = S_DN_KEY;
            end
          end
        end
      end
      S_UP_ADDR: state_next = (pos == '0) ? S_IDLE : S_UP_READ;
      S_UP_READ: state_next = S_UP_CMP;
      S_UP_CMP:  state_next = up_move ? S_UP_ADDR : S_IDLE;
      S_DN_KEY:  state_next = S_DN_ADDR;
      S_DN_ADDR: state_next = (first >= cnt_ext) ? S_IDLE : S_DN_RD0;
      S_DN_RD0:  state_next = S_DN_RD1;
      S_DN_RD1:  state_next = c1_ok ? S_DN_RD2 : S_DN_CMP;
      S_DN_RD2:  state_next = c2_ok ? S_DN_WAIT : S_DN_CMP;
      S_DN_WAIT: state_next = S_DN_CMP;
      S_DN_CMP:  state_next = dn_move ? S_DN_ADDR : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign finish = (state_next == S_IDLE) && (busy || accept);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (mem_waddr == '0)) begin
      top <= mem_wdata;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          hkey <= req.key_in;
          pos  <= AW'(count);
          if (req.cmd == CMD_INSERT) begin
            removed <= NEG_ONE;
            status  <= full ? ST_FULL : ST_DONE;
          end else if (count == '0) begin
            removed <= NEG_ONE;
            status  <= ST_EMPTY;
          end else begin
            removed <= top;
            status  <= ST_DONE;
          end
        end
      end
      S_UP_ADDR: begin
        parent <= parent_calc;
      end
      S_UP_CMP: begin
        if (up_move) begin
          pos <= parent;
        end
      end
      S_DN_KEY: begin
        hkey <= mem_rdata;
        pos  <= '0;
      end
      S_DN_ADDR: begin
        c0 <= first;
      end
      S_DN_RD1: begin
        best_key <= mem_rdata;
        best_idx <= AW'(c0);
      end
      S_DN_RD2: begin
        // ties keep the lower index
        if (c1_ok && (best_key < mem_rdata)) begin
          best_key <= mem_rdata;
          best_idx <= AW'(c1);
        end
      end
      S_DN_WAIT: begin
        if (best_key < mem_rdata) begin
          best_key <= mem_rdata;
          best_idx <= AW'(c2);
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          pos <= best_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.removed_key = removed;
    rsp.status      = status;
    rsp.top_key     = (count == '0) ? NEG_ONE : top;
    rsp.heap_empty  = (count == '0);
    rsp.entry_count = CNT_OUT_W'(count);
  end

  `TMHQ_ASSERT(a_done_not_busy, clk, rst, !(done && busy))
  `TMHQ_ASSERT_ALWAYS(a_count_bound, clk, !rst |-> (IW'(count) <= IW'(HEAP_DEPTH)))
  `TMHQ_ASSERT(a_write_in_heap, clk, rst, mem_we |-> (IW'(mem_waddr) < cnt_ext))
  `TMHQ_ASSERT(a_remove_shrinks, clk, rst, rm_taken |=> (count == $past(count) - CNT_W'(1)))
  `TMHQ_ASSERT(a_drop_is_quick, clk, rst, ins_dropped |=> (done && (status == ST_FULL)))

endmodule

/* rtl/core/ternary_max_heap_queue_core.sv */
// ----------------------------------------------------------------------------
// ternary_max_heap_queue_core
// 3-ary max-heap priority queue of signed 32-bit keys
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; its result
// appears on rsp for exactly one cycle with done high, in the cycle after
// the last busy cycle, and must be taken then, there is no backpressure.
// Each level of a sift goes through the single read port of the heap
// store. An insert keeps busy high while it climbs, one level at a time
// through its address, read and compare states. A remove keeps busy high
// while it descends, reading each child of a level in turn (one read per
// child) before the compare. A dropped insert, a remove on an empty heap
// and a remove of the last key finish without raising busy, with done high
// in the cycle after they are accepted. capacity_limit may be rewritten
// only while busy is low.
module ternary_max_heap_queue_core #(
  parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tmhq_pkg::item_t               req,
  output logic                          done,
  output tmhq_pkg::result_t             rsp,
  input  logic                          cfg_we,
  input  logic [tmhq_pkg::CAP_W-1:0]    cfg_data
);
  import tmhq_pkg::*;

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_limit;
  logic [CNT_W-1:0] count;
  logic             full;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_data;
    end
  end

  // effective capacity is the register clamped to the store depth
  assign full = (CMP_W'(count) >= CMP_W'(capacity_limit)) ||
                (count >= CNT_W'(HEAP_DEPTH));

  tmhq_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .full  (full),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp),
    .count (count)
  );

endmodule
